// ===== design/qeod_pkg.sv =====
// Shared types and constants for the quadrature encoder odometry block.
`timescale 1ns / 1ps
package qeod_pkg;

  localparam int DEF_COUNT_WIDTH = 32;
  localparam int WHEEL_COUNT     = 4;
  localparam int DELTA_WIDTH     = 32;

  // Wheel positions in the line and mask vectors
  localparam int WHEEL_FR = 0;
  localparam int WHEEL_FL = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  localparam logic [WHEEL_COUNT-1:0] INVERT_MASK_RESET = 4'b0100;
  localparam logic [WHEEL_COUNT-1:0] A_LEVELS_RESET    = 4'b1111;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // Sample word handed to the wheel counters
  typedef struct packed {
    logic                   en;
    logic [WHEEL_COUNT-1:0] a_lines;
    logic [WHEEL_COUNT-1:0] b_lines;
  } sample_cmd_t;

endpackage

// ===== design/qeod_wheel_counter.sv =====
// Edge detection on the A lines and the four up/down wheel counters.
`timescale 1ns / 1ps
module qeod_wheel_counter
  import qeod_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sample_cmd_t                             cmd,
  input  logic [WHEEL_COUNT-1:0]                  invert_mask,
  output logic [WHEEL_COUNT-1:0][COUNT_WIDTH-1:0] counts
);

  logic [WHEEL_COUNT-1:0] prev_a;
  logic [WHEEL_COUNT-1:0] rise;
  logic [WHEEL_COUNT-1:0] up;
  logic [WHEEL_COUNT-1:0][COUNT_WIDTH-1:0] counts_next;

  assign rise = cmd.a_lines & ~prev_a;
  assign up   = cmd.b_lines ^ invert_mask;

  always_comb begin
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      if (rise[i]) begin
        counts_next[i] = up[i] ? counts[i] + COUNT_WIDTH'(1) : counts[i] - COUNT_WIDTH'(1);
      end else begin
        counts_next[i] = counts[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a <= A_LEVELS_RESET;
      counts <= '0;
    end else if (cmd.en) begin
      prev_a <= cmd.a_lines;
      counts <= counts_next;
    end
  end

endmodule

// ===== design/qeod_side_average.sv =====
// Side averages, deltas against the previous read, and the stored averages.
`timescale 1ns / 1ps
module qeod_side_average
  import qeod_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    read_en,
  input  logic [WHEEL_COUNT-1:0][COUNT_WIDTH-1:0] counts,
  output logic signed [DELTA_WIDTH-1:0]           left_delta,
  output logic signed [DELTA_WIDTH-1:0]           right_delta
);

  localparam int SumWidth = COUNT_WIDTH + 1;

  logic signed [SumWidth-1:0]    left_sum, right_sum;
  logic signed [SumWidth-1:0]    left_adj, right_adj;
  logic        [COUNT_WIDTH-1:0] left_avg, right_avg;
  logic        [COUNT_WIDTH-1:0] last_left, last_right;
  logic signed [COUNT_WIDTH-1:0] left_diff, right_diff;

  assign left_sum  = SumWidth'(signed'(counts[WHEEL_FL])) + SumWidth'(signed'(counts[WHEEL_RL]));
  assign right_sum = SumWidth'(signed'(counts[WHEEL_FR])) + SumWidth'(signed'(counts[WHEEL_RR]));

  // Add one to negative sums so the halving truncates toward zero
  assign left_adj  = left_sum + {{(SumWidth-1){1'b0}}, left_sum[SumWidth-1]};
  assign right_adj = right_sum + {{(SumWidth-1){1'b0}}, right_sum[SumWidth-1]};

  assign left_avg  = left_adj[SumWidth-1:1];
  assign right_avg = right_adj[SumWidth-1:1];

  assign left_diff  = left_avg - last_left;
  assign right_diff = right_avg - last_right;

  assign left_delta  = DELTA_WIDTH'(left_diff);
  assign right_delta = DELTA_WIDTH'(right_diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
    end else if (read_en) begin
      last_left  <= left_avg;
      last_right <= right_avg;
    end
  end

endmodule

// ===== design/quad_encoder_odometry_delta.sv =====
// Top level of the four-wheel quadrature encoder odometry block.
// A read word is held in the input register, then loads the result register when it advances.
// Throughput: one word per cycle; sample words never wait, but a read word held in
// the input register by a full, stalled result register stalls the input.
// Synchronous active-high reset clears the wheel counts and stored averages, sets
// the A history to all ones and the invert mask to rear left.
`timescale 1ns / 1ps
module quad_encoder_odometry_delta
  import qeod_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [WHEEL_COUNT-1:0]        a_lines,
  input  logic [WHEEL_COUNT-1:0]        b_lines,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DELTA_WIDTH-1:0] left_delta,
  output logic signed [DELTA_WIDTH-1:0] right_delta,
  input  logic                          cfg_we,
  input  logic [WHEEL_COUNT-1:0]        cfg_wdata
);

  logic                   invert_mask;
  logic [WHEEL_COUNT-1:0] direction_invert_mask;

  logic                   s1_valid;
  op_t                    s1_op;
  logic [WHEEL_COUNT-1:0] s1_a;
  logic [WHEEL_COUNT-1:0] s1_b;

  logic        accept;
  logic        out_free;
  logic        advance;
  logic        read_en;
  sample_cmd_t sample_cmd;

  logic [WHEEL_COUNT-1:0][COUNT_WIDTH-1:0] counts;
  logic signed [DELTA_WIDTH-1:0]           left_delta_next, right_delta_next;

  assign invert_mask = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_invert_mask <= INVERT_MASK_RESET;
    end else if (cfg_we) begin
      direction_invert_mask <= cfg_wdata;
    end
  end

  // Sample words never wait on the output; read words need a free result slot
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && ((s1_op == OP_SAMPLE) || out_free);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign read_en  = advance && (s1_op == OP_READ);

  assign sample_cmd.en      = advance && (s1_op == OP_SAMPLE);
  assign sample_cmd.a_lines = s1_a;
  assign sample_cmd.b_lines = s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= op_t'(operation);
      s1_a  <= a_lines;
      s1_b  <= b_lines;
    end
  end

  qeod_wheel_counter #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_wheel_counter (
    .clk        (clk),
    .rst        (rst),
    .cmd        (sample_cmd),
    .invert_mask(direction_invert_mask ^ {WHEEL_COUNT{invert_mask}}),
    .counts     (counts)
  );

  qeod_side_average #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_side_average (
    .clk        (clk),
    .rst        (rst),
    .read_en    (read_en),
    .counts     (counts),
    .left_delta (left_delta_next),
    .right_delta(right_delta_next)
  );

  // Result register: hold while stalled, load on a read word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (read_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_en) begin
      left_delta  <= left_delta_next;
      right_delta <= right_delta_next;
    end
  end

endmodule
